/* src/sobm_pkg.sv */
`default_nettype none
package sobm_pkg;

	// Default frame store limits
	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

	// Configuration registers
	localparam int CFG_W = 12;
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;
	localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd640;
	localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;

	// Input opcodes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} sobm_in_t;

	typedef struct packed {
		logic [7:0] red_edge;
		logic [7:0] green_edge;
		logic [7:0] blue_edge;
		logic       frame_end;
	} sobm_out_t;

	// Per-item classification handed from front to back
	typedef struct packed {
		logic emit;     // item releases a result
		logic last;     // result is the frame's last pixel
		logic left_z;   // left column outside the frame
		logic right_z;  // right column outside the frame
		logic top_z;    // top row outside the frame
		logic bot_z;    // bottom row outside the frame
	} sobm_flags_t;

endpackage
`default_nettype wire

/* src/sobm_fifo.sv */
`default_nettype none
module sobm_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr,
	input  wire logic [W-1:0] wdata,
	input  wire logic         rd,
	output logic      [W-1:0] rdata,
	output logic              full,
	output logic              empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	// Storage
	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wp_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !full) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd && !empty) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(wr && !full) - CW'(rd && !empty);
		end
	end

endmodule
`default_nettype wire

/* src/sobm_front.sv */
`default_nettype none
module sobm_front
	import sobm_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr,
	input  wire logic                         cfg_index,
	input  wire logic [CFG_W-1:0]             cfg_data,
	input  wire logic                         push,
	input  wire sobm_in_t                     pixel,
	input  wire logic                         q_full,
	output logic                              q_push,
	output logic [$clog2(MAX_WIDTH)-1:0]      q_col,
	output logic [23:0]                       q_px,
	output sobm_flags_t                       q_flags
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 3);

	logic [CFG_W-1:0] frame_width_q, frame_height_q;
	logic [WW-1:0]    col_q;
	logic [RW-1:0]    row_q;

	logic [31:0] fw, fh, w, h, col_e, row_e, cr, nc;
	logic        wrap, col0, emit, beyond, lst, accept;

	assign accept = push && !q_full;
	assign q_push = accept;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Position of this request and its classification
	always_comb begin
		fw = 32'(frame_width_q);
		fh = 32'(frame_height_q);
		w  = (fw == 0) ? 32'd1 : ((fw > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : fw);
		h  = (fh == 0) ? 32'd1 : ((fh > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : fh);

		// stale column after a width change wraps to the next row
		wrap  = (32'(col_q) >= w);
		col_e = wrap ? 32'd0 : 32'(col_q);
		row_e = wrap ? 32'(row_q) + 32'd1 : 32'(row_q);
		col0  = (col_e == 0);

		// result trails the input by one row and one pixel
		emit   = (row_e >= 32'd2) || (row_e == 32'd1 && col_e >= 32'd1);
		cr     = col0 ? row_e - 32'd2 : row_e - 32'd1;
		beyond = (cr >= h);
		lst    = !beyond && (cr == h - 32'd1) && col0;
		nc     = col_e + 32'd1;

		q_col           = AW'(col_e);
		q_flags.emit    = emit && !beyond;
		q_flags.last    = emit && lst;
		q_flags.left_z  = col0 ? (w == 32'd1) : (col_e == 32'd1);
		q_flags.right_z = col0;
		q_flags.top_z   = (cr == 32'd0);
		q_flags.bot_z   = (cr + 32'd1 >= h);

		// drain items and pixels past the frame enter as black
		if (pixel.opcode == OP_DRAIN || row_e >= h) begin
			q_px = '0;
		end else begin
			q_px = {pixel.red_in, pixel.green_in, pixel.blue_in};
		end
	end

	// Raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (emit && (beyond || lst)) begin
				col_q <= '0;
				row_q <= '0;
			end else if (nc >= w) begin
				col_q <= '0;
				row_q <= RW'(row_e + 32'd1);
			end else begin
				col_q <= WW'(nc);
				row_q <= RW'(row_e);
			end
		end
	end

endmodule
`default_nettype wire

/* src/sobm_back.sv */
`default_nettype none
module sobm_back
	import sobm_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_empty,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]  q_col,
	input  wire logic [23:0]                   q_px,
	input  wire sobm_flags_t                   q_flags,
	output logic                               q_pop,
	input  wire logic                          res_full,
	output logic                               res_push,
	output sobm_out_t                          res
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int NR = 8;   // one root bit per stage

	// Line stores, no reset
	logic [23:0] up_mem  [MAX_WIDTH];
	logic [23:0] mid_mem [MAX_WIDTH];

	// Store read stage
	logic          v_s1, hz_s1;
	logic [AW-1:0] col_s1;
	logic [23:0]   px_s1, rd_up_s1, rd_mid_s1;
	sobm_flags_t   fl_s1;
	logic [23:0]   fw_up_q, fw_mid_q;
	logic [23:0]   up_val, mid_val;

	// Window
	logic [23:0] win_q [3][3];
	logic [23:0] a [3][3];
	logic [23:0] nc [3];

	// Gradient and square stages
	logic              v_s2, last_s2, v_s3, last_s3;
	logic signed [10:0] gx_s2 [3], gy_s2 [3];
	logic signed [10:0] gx [3], gy [3];
	logic [20:0]       sum_s3 [3];
	logic [7:0]        px_c [3][3][3];
	logic [9:0]        pa, pb;

	// Root stages
	logic        rv_s   [NR];
	logic        rlast_s [NR];
	logic [7:0]  r_s    [NR][3];
	logic [20:0] sq_s   [NR][3];

	logic adv;

	// One trial bit of the rounded root: keep t when t*(t-1) < s
	function automatic logic [7:0] root_step(input logic [7:0] r, input logic [20:0] s,
		input logic [2:0] b);
		logic [7:0]  t;
		logic [15:0] p;
		t = r | (8'd1 << b);
		p = 16'(t) * 16'(t - 8'd1);
		return ({5'd0, p} < s) ? t : r;
	endfunction

	assign adv   = !(rv_s[NR-1] && res_full);
	assign q_pop = adv && !q_empty;

	// Forward the previous write when it hit the address read in the same cycle
	assign up_val  = hz_s1 ? fw_up_q  : rd_up_s1;
	assign mid_val = hz_s1 ? fw_mid_q : rd_mid_s1;
	assign nc[0] = up_val;
	assign nc[1] = mid_val;
	assign nc[2] = px_s1;

	// Neighbourhood of the released result, out-of-frame taps zeroed
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a[i][0] = win_q[i][1];
			a[i][1] = win_q[i][2];
			a[i][2] = nc[i];
			if (fl_s1.left_z)  a[i][0] = '0;
			if (fl_s1.right_z) a[i][2] = '0;
		end
		for (int j = 0; j < 3; j++) begin
			if (fl_s1.top_z) a[0][j] = '0;
			if (fl_s1.bot_z) a[2][j] = '0;
		end
	end

	// Sobel gradients per channel
	always_comb begin
		pa = '0;
		pb = '0;
		for (int c = 0; c < 3; c++) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					px_c[c][i][j] = a[i][j][23 - 8*c -: 8];
				end
			end
			pa = 10'(px_c[c][0][2]) + {1'b0, px_c[c][1][2], 1'b0} + 10'(px_c[c][2][2]);
			pb = 10'(px_c[c][0][0]) + {1'b0, px_c[c][1][0], 1'b0} + 10'(px_c[c][2][0]);
			gx[c] = $signed({1'b0, pa}) - $signed({1'b0, pb});
			pa = 10'(px_c[c][0][0]) + {1'b0, px_c[c][0][1], 1'b0} + 10'(px_c[c][0][2]);
			pb = 10'(px_c[c][2][0]) + {1'b0, px_c[c][2][1], 1'b0} + 10'(px_c[c][2][2]);
			gy[c] = $signed({1'b0, pa}) - $signed({1'b0, pb});
		end
	end

	// Store read, store write-back and forwarding copies of the write
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_up_s1  <= up_mem[q_col];
			rd_mid_s1 <= mid_mem[q_col];
			col_s1    <= q_col;
			px_s1     <= q_px;
			fl_s1     <= q_flags;
		end
		if (adv && v_s1) begin
			up_mem[col_s1]  <= mid_val;
			mid_mem[col_s1] <= px_s1;
			fw_up_q         <= mid_val;
			fw_mid_q        <= px_s1;
		end
	end

	// Window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (adv && v_s1) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
				win_q[i][2] <= nc[i];
			end
		end
	end

	// Arithmetic payload: gradients, squares, root bits
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2 <= fl_s1.last;
			last_s3 <= last_s2;
			for (int c = 0; c < 3; c++) begin
				gx_s2[c]    <= gx[c];
				gy_s2[c]    <= gy[c];
				sum_s3[c]   <= 21'(gx_s2[c]) * 21'(gx_s2[c]) + 21'(gy_s2[c]) * 21'(gy_s2[c]);
				r_s[0][c]   <= root_step(8'd0, sum_s3[c], 3'(NR - 1));
				sq_s[0][c]  <= sum_s3[c];
			end
			rlast_s[0] <= last_s3;
			for (int k = 1; k < NR; k++) begin
				rlast_s[k] <= rlast_s[k-1];
				for (int c = 0; c < 3; c++) begin
					r_s[k][c]  <= root_step(r_s[k-1][c], sq_s[k-1][c], 3'(NR - 1 - k));
					sq_s[k][c] <= sq_s[k-1][c];
				end
			end
		end
	end

	// Stage valids and forwarding hazard
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			hz_s1 <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			for (int k = 0; k < NR; k++) begin
				rv_s[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s1 <= !q_empty;
			if (!q_empty) begin
				hz_s1 <= v_s1 && (q_col == col_s1);
			end
			v_s2    <= v_s1 && fl_s1.emit;
			v_s3    <= v_s2;
			rv_s[0] <= v_s3;
			for (int k = 1; k < NR; k++) begin
				rv_s[k] <= rv_s[k-1];
			end
		end
	end

	assign res_push       = adv && rv_s[NR-1];
	assign res.red_edge   = r_s[NR-1][0];
	assign res.green_edge = r_s[NR-1][1];
	assign res.blue_edge  = r_s[NR-1][2];
	assign res.frame_end  = rlast_s[NR-1];

endmodule
`default_nettype wire

/* src/sobel_edge_magnitude_rgb.sv */
// Streaming 3x3 Sobel edge magnitude on RGB pixels.
// Input channel: pixel (opcode plus RGB) is taken at a clock edge with push
// high and full low. Pixels come in raster order; after the frame's last
// pixel, frame_width+1 drain requests flush the tail.
// Result channel: while empty is low the oldest result sits on result and is
// taken at an edge with pop high. frame_end marks the frame's last result.
// Configuration: cfg_wr writes cfg_data into frame_width (index 0) or
// frame_height (index 1) at once; write only while the block is idle.
// Throughput: one request per cycle while full is low. The result for pixel p
// is released by request p+frame_width+1 and, once that request is taken,
// passes through the queue, line store read, gradient, square, eight root-bit
// stages and the output queue to the result port.
// Stalls: when result is not popped the back pipeline holds, the two-entry
// queue fills and full rises; nothing is dropped.
// Reset clears counters, window and queues, and restores 640 by 480; the
// line stores are not cleared and need no clearing pass.
`default_nettype none
module sobel_edge_magnitude_rgb
	import sobm_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             push,
	output logic                  full,
	input  wire sobm_in_t         pixel,
	output logic                  empty,
	input  wire logic             pop,
	output sobm_out_t             result
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int QW = AW + 24 + $bits(sobm_flags_t);
	localparam int OW = $bits(sobm_out_t);

	logic          f_push, q_full, q_empty, q_pop;
	logic [AW-1:0] f_col, b_col;
	logic [23:0]   f_px, b_px;
	sobm_flags_t   f_flags, b_flags;
	logic [QW-1:0] q_rdata;
	logic          res_push, res_full;
	sobm_out_t     res;
	logic [OW-1:0] o_rdata;

	assign full = q_full;

	sobm_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (push),
		.pixel    (pixel),
		.q_full   (q_full),
		.q_push   (f_push),
		.q_col    (f_col),
		.q_px     (f_px),
		.q_flags  (f_flags)
	);

	// Queue between classification and arithmetic
	sobm_fifo #(
		.W    (QW),
		.DEPTH(2)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (f_push),
		.wdata ({f_col, f_px, f_flags}),
		.rd    (q_pop),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	assign {b_col, b_px, b_flags} = q_rdata;

	sobm_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_col   (b_col),
		.q_px    (b_px),
		.q_flags (b_flags),
		.q_pop   (q_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res     (res)
	);

	// Output register queue
	sobm_fifo #(
		.W    (OW),
		.DEPTH(2)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.wdata (res),
		.rd    (pop),
		.rdata (o_rdata),
		.full  (res_full),
		.empty (empty)
	);

	assign result = o_rdata;

endmodule
`default_nettype wire

/* src/sobm_checker.sv */
`default_nettype none
module sobm_checker
	import sobm_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      push,
	input wire logic      full,
	input wire logic      empty,
	input wire logic      pop,
	input wire sobm_out_t result
);

	// Reset leaves no result pending
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result pending during reset");

	// A waiting result holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed");

	// The input queue fills only from a request
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a request");

endmodule

bind sobel_edge_magnitude_rgb sobm_checker u_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.push  (push),
	.full  (full),
	.empty (empty),
	.pop   (pop),
	.result(result)
);
`default_nettype wire
